@@ hw/rtl/top_k_nearest_selector_defines.svh @@
// assertion helpers used by top_k_nearest_selector.sv
`ifndef TOP_K_NEAREST_SELECTOR_DEFINES_SVH
`define TOP_K_NEAREST_SELECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TKNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TKNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tkns_pkg.sv @@
`default_nettype none

package tkns_pkg;

  localparam int KLIM_W     = 7;
  localparam int DIST_W     = 32;
  localparam int ID_W       = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_K_LIMIT      = 2'd0,
    REG_MAX_DISTANCE = 2'd1,
    REG_MAX_DIST_EN  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // per-cell position info derived from the fill count
  typedef struct packed {
    logic valid;
    logic is_last;
  } cell_pos_t;

endpackage

`default_nettype wire

@@ hw/rtl/top_k_nearest_selector.sv @@
// top_k_nearest_selector: keeps the k closest (distance, id) pairs of a search
//
// command channel: start with command, distance, entity_id; a word is taken on
//   a clock edge with start high and busy low
// offer (command 0): busy stays low, so an offer can be given every cycle;
//   it never produces a result word
// drain (command 1): busy rises in the next cycle and the held entries come out
//   in ascending (distance, id) order, one per cycle on result_id and
//   result_distance with result_valid, last marking the final one; the first
//   word appears the cycle after the drain is taken, n words for n held entries,
//   busy falls in the cycle after last; an empty drain or k of 0 emits nothing
// rate is set by the chain of cells: every cell compares the offered word with
//   its entry in parallel, and a drain shifts the chain down one cell per cycle
// config: cfg_we, cfg_index, cfg_data write k_limit, max_distance and
//   max_distance_enable; write only while idle
// reset (rst, synchronous) empties the store and loads k_limit 64, max_distance
//   0x7fffffff, filter off; the stored words need no clearing
// the receiver cannot stall: each result word is shown for exactly one cycle
`default_nettype none

`include "top_k_nearest_selector_defines.svh"

module top_k_nearest_selector
  import tkns_pkg::*;
#(
  parameter int MAX_K = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     command,
  input  wire logic signed [DIST_W-1:0] distance,
  input  wire logic [ID_W-1:0]          entity_id,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                          result_valid,
  output logic [ID_W-1:0]               result_id,
  output logic signed [DIST_W-1:0]      result_distance,
  output logic                          last
);

  localparam int CNT_W = $clog2(MAX_K + 1);

  // configuration registers
  logic [KLIM_W-1:0]        k_limit;
  logic signed [DIST_W-1:0] max_distance;
  logic                     max_distance_enable;

  // fill count and drain control
  logic [CNT_W-1:0] count, count_next;
  state_t           state, state_next;

  // chain wiring
  logic signed [DIST_W-1:0] cell_dist [MAX_K];
  logic [ID_W-1:0]          cell_id   [MAX_K];
  logic [MAX_K-1:0]         cell_lt;
  logic [MAX_K-1:0]         cell_beats;
  logic [MAX_K-1:0]         valid;
  cell_pos_t                pos [MAX_K];
  cell_ctrl_t               ctrl;

  logic [KLIM_W-1:0] k_eff;
  logic              offer;
  logic              drain;
  logic              pass_filter;
  logic              full;
  logic              insert;

  // config writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      k_limit             <= KLIM_W'(64);
      max_distance        <= 32'sh7fff_ffff;
      max_distance_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_K_LIMIT:      k_limit             <= cfg_data[KLIM_W-1:0];
        REG_MAX_DISTANCE: max_distance        <= cfg_data[DIST_W-1:0];
        REG_MAX_DIST_EN:  max_distance_enable <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // k above the chain length acts as the chain length
  assign k_eff = (k_limit > KLIM_W'(MAX_K)) ? KLIM_W'(MAX_K) : k_limit;

  // a cell holds an entry when its place is below the fill count
  for (genvar i = 0; i < MAX_K; i++) begin : g_pos
    assign valid[i] = count > CNT_W'(i);
    if (i == MAX_K - 1) begin : g_end
      assign pos[i].is_last = valid[i];
    end else begin : g_mid
      assign pos[i].is_last = valid[i] && !valid[i+1];
    end
    assign pos[i].valid = valid[i];
  end

  assign offer       = start && !busy && (command == CMD_OFFER);
  assign drain       = start && !busy && (command == CMD_DRAIN);
  assign pass_filter = !(max_distance_enable && (distance > max_distance));
  assign full        = KLIM_W'(count) >= k_eff;
  // when full the word must be strictly closer than the largest held entry,
  // which then moves past the fill count and is dropped
  assign insert      = offer && (k_eff != '0) && pass_filter &&
                       (!full || (|cell_beats));

  assign ctrl.insert = insert;
  assign ctrl.shift  = (state == ST_DRAIN);

  // the chain: sorted ascending from cell 0
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic signed [DIST_W-1:0] l_dist, r_dist;
    logic [ID_W-1:0]          l_id, r_id;
    logic                     l_lt;
    if (i == 0) begin : g_first
      assign l_dist = distance;
      assign l_id   = entity_id;
      assign l_lt   = 1'b0;
    end else begin : g_left
      assign l_dist = cell_dist[i-1];
      assign l_id   = cell_id[i-1];
      assign l_lt   = cell_lt[i-1];
    end
    if (i == MAX_K - 1) begin : g_last
      assign r_dist = cell_dist[i];
      assign r_id   = cell_id[i];
    end else begin : g_right
      assign r_dist = cell_dist[i+1];
      assign r_id   = cell_id[i+1];
    end
    tkns_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .pos           (pos[i]),
      .new_distance  (distance),
      .new_id        (entity_id),
      .left_distance (l_dist),
      .left_id       (l_id),
      .left_lt       (l_lt),
      .right_distance(r_dist),
      .right_id      (r_id),
      .distance      (cell_dist[i]),
      .id            (cell_id[i]),
      .lt            (cell_lt[i]),
      .beats         (cell_beats[i])
    );
  end

  // fill count and drain sequencing
  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        if (drain) begin
          // k of 0 or nothing held: just empty the store
          if ((k_eff == '0) || (count == '0)) begin
            count_next = '0;
          end else begin
            state_next = ST_DRAIN;
          end
        end else if (insert && !full) begin
          count_next = count + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        count_next = count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // cell 0 always holds the smallest remaining entry
  assign busy            = (state == ST_DRAIN);
  assign result_valid    = (state == ST_DRAIN);
  assign result_id       = cell_id[0];
  assign result_distance = cell_dist[0];
  assign last            = (state == ST_DRAIN) && (count == CNT_W'(1));

  `TKNS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_K), "fill count beyond chain")
  `TKNS_ASSERT_NOW(a_word_held, result_valid, count != '0, "result word from empty chain")
  `TKNS_ASSERT_NEXT(a_last_frees, result_valid && last, !busy && (count == '0),
    "store not empty after last word")
  `TKNS_ASSERT_NEXT(a_fill, insert && !full, count == $past(count) + CNT_W'(1),
    "fill count missed an insert")

endmodule

`default_nettype wire

@@ hw/rtl/tkns_cell.sv @@
`default_nettype none

module tkns_cell
  import tkns_pkg::*;
(
  input  wire                       clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire cell_pos_t            pos,
  input  wire logic signed [DIST_W-1:0] new_distance,
  input  wire logic [ID_W-1:0]      new_id,
  input  wire logic signed [DIST_W-1:0] left_distance,
  input  wire logic [ID_W-1:0]      left_id,
  input  wire logic                 left_lt,
  input  wire logic signed [DIST_W-1:0] right_distance,
  input  wire logic [ID_W-1:0]      right_id,
  output logic signed [DIST_W-1:0]  distance,
  output logic [ID_W-1:0]           id,
  output logic                      lt,
  output logic                      beats
);

  logic signed [DIST_W-1:0] distance_next;
  logic [ID_W-1:0]          id_next;

  always_comb begin
    // new word sorts before this entry (empty cells count as +inf)
    lt    = !pos.valid || (new_distance < distance) ||
            ((new_distance == distance) && (new_id < id));
    // strictly closer than the largest held entry
    beats = pos.is_last && (new_distance < distance);
    distance_next = distance;
    id_next       = id;
    priority if (ctrl.shift) begin
      distance_next = right_distance;
      id_next       = right_id;
    end else if (ctrl.insert && lt && !left_lt) begin
      distance_next = new_distance;
      id_next       = new_id;
    end else if (ctrl.insert && lt) begin
      distance_next = left_distance;
      id_next       = left_id;
    end else begin
      // entry stays put
      distance_next = distance;
      id_next       = id;
    end
  end

  always_ff @(posedge clk) begin
    distance <= distance_next;
    id       <= id_next;
  end

endmodule

`default_nettype wire
